>>> rtl/core/cli_pkg.sv
package cli_pkg;

  // parser phases
  localparam logic [2:0] PH_COUNT  = 3'd0;
  localparam logic [2:0] PH_OPCODE = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_ARG    = 3'd3;
  localparam logic [2:0] PH_DELAY  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_DELAY = 2'd2;

  // delay byte coding
  localparam logic [7:0] DELAY_LONG_CODE = 8'd255;
  localparam logic [8:0] DELAY_LONG_MS   = 9'd500;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] value;
    logic       last;
  } result_t;

endpackage

>>> rtl/core/cli_in_stage.sv
module cli_in_stage
  import cli_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_script_byte,
  input  logic       proc,
  output logic       full,
  output logic [7:0] byte_q
);

  logic       full_r;
  logic       full_nxt;
  logic [7:0] byte_r;
  logic       in_fire;

  // input register is free when empty or drained this cycle
  assign in_stall = full_r && !proc;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    full_nxt = full_r;
    if (in_fire) begin
      full_nxt = 1'b1;
    end else if (proc) begin
      full_nxt = 1'b0;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // captured byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_script_byte;
    end
  end

  assign full   = full_r;
  assign byte_q = byte_r;

endmodule

>>> rtl/core/cli_parser.sv
module cli_parser
  import cli_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       proc,
  input  logic [7:0] script_byte,
  output logic       res_valid,
  output result_t    res
);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] cmds_left_r, cmds_left_nxt;
  logic [6:0] args_left_r, args_left_nxt;
  logic       delay_pend_r, delay_pend_nxt;
  logic [7:0] held_op_r, held_op_nxt;
  logic [6:0] args_hdr;
  logic [6:0] args_dec;
  logic [7:0] cmds_dec;
  logic [2:0] phase_fin;
  logic       cmds_one;

  assign args_hdr  = script_byte[6:0];
  assign args_dec  = args_left_r - 7'd1;
  assign cmds_dec  = cmds_left_r - 8'd1;
  assign cmds_one  = (cmds_left_r == 8'd1);
  assign phase_fin = (cmds_dec == 8'd0) ? PH_COUNT : PH_OPCODE;

  // one byte step of the script parser
  always_comb begin
    phase_nxt      = phase_r;
    cmds_left_nxt  = cmds_left_r;
    args_left_nxt  = args_left_r;
    delay_pend_nxt = delay_pend_r;
    held_op_nxt    = held_op_r;
    res_valid      = 1'b0;
    res.kind       = KIND_CMD;
    res.value      = {1'b0, held_op_r};
    res.last       = 1'b0;
    case (phase_r)
      PH_OPCODE: begin
        held_op_nxt = script_byte;
        phase_nxt   = PH_HEADER;
      end
      PH_HEADER: begin
        args_left_nxt  = args_hdr;
        delay_pend_nxt = script_byte[7];
        res_valid      = 1'b1;
        res.kind       = KIND_CMD;
        res.value      = {1'b0, held_op_r};
        res.last       = cmds_one && (args_hdr == 7'd0) && !script_byte[7];
        if (args_hdr != 7'd0) begin
          phase_nxt = PH_ARG;
        end else if (script_byte[7]) begin
          phase_nxt = PH_DELAY;
        end else begin
          cmds_left_nxt = cmds_dec;
          phase_nxt     = phase_fin;
        end
      end
      PH_ARG: begin
        args_left_nxt = args_dec;
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.value     = {1'b0, script_byte};
        res.last      = cmds_one && (args_dec == 7'd0) && !delay_pend_r;
        if (args_dec == 7'd0) begin
          if (delay_pend_r) begin
            phase_nxt = PH_DELAY;
          end else begin
            cmds_left_nxt = cmds_dec;
            phase_nxt     = phase_fin;
          end
        end
      end
      PH_DELAY: begin
        res_valid      = 1'b1;
        res.kind       = KIND_DELAY;
        res.value      = (script_byte == DELAY_LONG_CODE) ? DELAY_LONG_MS
                                                           : {1'b0, script_byte};
        res.last       = cmds_one;
        delay_pend_nxt = 1'b0;
        cmds_left_nxt  = cmds_dec;
        phase_nxt      = phase_fin;
      end
      default: begin
        // command count, also taken for unused phase codes
        cmds_left_nxt  = script_byte;
        args_left_nxt  = 7'd0;
        delay_pend_nxt = 1'b0;
        phase_nxt      = (script_byte == 8'd0) ? PH_COUNT : PH_OPCODE;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      cmds_left_r  <= 8'd0;
      args_left_r  <= 7'd0;
      delay_pend_r <= 1'b0;
      held_op_r    <= 8'd0;
    end else if (proc) begin
      phase_r      <= phase_nxt;
      cmds_left_r  <= cmds_left_nxt;
      args_left_r  <= args_left_nxt;
      delay_pend_r <= delay_pend_nxt;
      held_op_r    <= held_op_nxt;
    end
  end

endmodule

>>> rtl/core/cli_out_stage.sv
module cli_out_stage
  import cli_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    res,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [8:0] out_value,
  output logic       out_last
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // register may take a new result when empty or being taken
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = res_r.kind;
  assign out_value = res_r.value;
  assign out_last  = res_r.last;

endmodule

>>> rtl/core/init_command_list_interpreter.sv
// Display initialisation script interpreter.
// Input channel: in_valid / in_stall carry one script byte (in_script_byte)
// per transfer. The first byte of a script is the command count, then per
// command an opcode byte, an argument header byte (bit 7 delay flag, bits
// 6..0 argument count), the argument bytes and an optional delay byte.
// Output channel: out_valid / out_stall carry command, data or delay items
// (out_kind, out_value, out_last); out_last marks the final item of a script.
// Count and opcode bytes give no item; a delay byte of 255 reads as 500 ms.
// Each transferred byte is captured in the input register; its item is then
// held in the result register, which drives the output.
// Throughput: one byte per cycle while the receiver does not stall, with a
// combinational parser step between the input and result registers.
// When the receiver stalls, the result register holds its item, the parser
// waits and in_stall rises once the input register is occupied.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to expecting a command count.
module init_command_list_interpreter
  import cli_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_script_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [8:0] out_value,
  output logic       out_last
);

  logic       in_full;
  logic [7:0] byte_q;
  logic       out_ready;
  logic       proc;
  logic       res_valid;
  result_t    res;

  // parse a held byte whenever the result register can take its item
  assign proc = in_full && out_ready;

  cli_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_script_byte (in_script_byte),
    .proc           (proc),
    .full           (in_full),
    .byte_q         (byte_q)
  );

  cli_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .script_byte (byte_q),
    .res_valid   (res_valid),
    .res         (res)
  );

  cli_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc && res_valid),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cli_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BYTES  = 285;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_script_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [8:0] out_value;
  logic       out_last;

  init_command_list_interpreter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_script_byte(in_script_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_last      (out_last)
  );

  always #4 clk = ~clk;

  // bytes waiting to be driven and items waiting to come out
  logic [7:0] script_bytes [$];
  result_t    expected_items [$];

  // parser mirror
  logic [2:0] ph = PH_COUNT;
  logic [7:0] cmds_left = 8'd0;
  logic [6:0] args_left = 7'd0;
  logic       delay_due = 1'b0;
  logic [7:0] held_op = 8'd0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int bytes_in = 0;
  int n_cmd = 0;
  int n_data = 0;
  int n_delay = 0;
  int n_long = 0;
  int n_last = 0;
  result_t want;

  // opening script: empty script, delays of 500, 0 and 254 ms, last on each kind
  logic [7:0] opening [0:23] = '{
    8'h00,
    8'h03, 8'h00, 8'h00,
    8'hFF, 8'h82, 8'hAA, 8'h55, 8'hFF,
    8'h5A, 8'h81, 8'h00, 8'h00,
    8'h01, 8'h11, 8'h00,
    8'h01, 8'h22, 8'h01, 8'hFF,
    8'h01, 8'h33, 8'h80, 8'hFE
  };

  function automatic void add_result(logic [1:0] kind, logic [8:0] value, logic last);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    expected_items.push_back(r);
  endfunction

  function automatic void close_command();
    cmds_left = cmds_left - 8'd1;
    ph = (cmds_left == 8'd0) ? PH_COUNT : PH_OPCODE;
  endfunction

  function automatic void leave_args();
    if (delay_due) ph = PH_DELAY;
    else close_command();
  endfunction

  // advance the mirror by one accepted script byte
  function automatic void interpret_byte(logic [7:0] b);
    case (ph)
      PH_OPCODE: begin
        held_op = b;
        ph = PH_HEADER;
      end
      PH_HEADER: begin
        args_left = b[6:0];
        delay_due = b[7];
        add_result(KIND_CMD, {1'b0, held_op},
                   cmds_left == 8'd1 && args_left == 7'd0 && !delay_due);
        if (args_left != 7'd0) ph = PH_ARG;
        else leave_args();
      end
      PH_ARG: begin
        args_left = args_left - 7'd1;
        add_result(KIND_DATA, {1'b0, b},
                   cmds_left == 8'd1 && args_left == 7'd0 && !delay_due);
        if (args_left == 7'd0) leave_args();
      end
      PH_DELAY: begin
        add_result(KIND_DELAY, (b == DELAY_LONG_CODE) ? DELAY_LONG_MS : {1'b0, b},
                   cmds_left == 8'd1);
        delay_due = 1'b0;
        close_command();
      end
      default: begin
        cmds_left = b;
        args_left = 7'd0;
        delay_due = 1'b0;
        ph = (b == 8'd0) ? PH_COUNT : PH_OPCODE;
      end
    endcase
  endfunction

  // one well-formed script with random content
  function automatic int add_script();
    int count, argc, r, added;
    bit slim, flag;
    added = 0;
    r = $urandom_range(99, 0);
    slim = 1'b0;
    if (r < 8) count = 0;
    else if (r < 85) count = $urandom_range(4, 1);
    else if (r < 99) count = $urandom_range(12, 5);
    else begin
      count = $urandom_range(255, 13);
      slim = 1'b1;
    end
    script_bytes.push_back(count[7:0]);
    added++;
    for (int c = 0; c < count; c++) begin
      r = $urandom_range(99, 0);
      if (slim || r < 50) argc = $urandom_range(2, 0);
      else if (r < 85) argc = $urandom_range(8, 3);
      else if (r < 97) argc = $urandom_range(30, 9);
      else argc = $urandom_range(127, 31);
      flag = slim ? 1'b0 : $urandom_range(1, 0);
      script_bytes.push_back(8'($urandom_range(255, 0)));
      script_bytes.push_back({flag, argc[6:0]});
      added += 2;
      for (int a = 0; a < argc; a++) begin
        script_bytes.push_back(8'($urandom_range(255, 0)));
        added++;
      end
      if (flag) begin
        script_bytes.push_back(($urandom_range(99, 0) < 30) ? DELAY_LONG_CODE
                                                          : 8'($urandom_range(255, 0)));
        added++;
      end
    end
    return added;
  endfunction

  // random part of a phase: mostly scripts, some stray or truncated bytes
  function automatic void fill_phase();
    int added, n;
    added = 0;
    while (added < PHASE_BYTES) begin
      if ($urandom_range(99, 0) < 6) begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) script_bytes.push_back(8'($urandom_range(255, 0)));
        added += n;
      end else begin
        added += add_script();
      end
    end
  endfunction

  // short runs with no idling on either side
  always @(posedge clk) begin
    if (burst_left > 0) burst_left <= burst_left - 1;
    else if ($urandom_range(99, 0) < 3) burst_left <= $urandom_range(30, 10);
  end

  // input driver, mirror updated on each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        interpret_byte(in_script_byte);
        bytes_in <= bytes_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (script_bytes.size() > 0 &&
            (burst_left > 0 || $urandom_range(99, 0) >= send_idle_pct)) begin
          in_valid       <= 1'b1;
          in_script_byte <= script_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (burst_left == 0) && ($urandom_range(99, 0) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        $error("unexpected item: kind %0d value %0d last %0d", out_kind, out_value, out_last);
        errors++;
      end else begin
        want = expected_items.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          errors++;
        end
        if (out_value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_value);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
        case (want.kind)
          KIND_CMD:  n_cmd++;
          KIND_DATA: n_data++;
          default: begin
            n_delay++;
            if (want.value == DELAY_LONG_MS) n_long++;
          end
        endcase
        if (want.last) n_last++;
      end
    end
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (script_bytes.size() > 0 || in_valid || expected_items.size() > 0) begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // phase sequencing
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      case (p)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 64; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 64; end
        default: begin send_idle_pct <= 29; stall_pct <= 29; end
      endcase
      if (p == 0) foreach (opening[i]) script_bytes.push_back(opening[i]);
      fill_phase();
      while (script_bytes.size() > 0 || in_valid || expected_items.size() > 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_items.size() != 0) errors++;
    $display("covered %0d script bytes over four idling phases", bytes_in);
    $display("items: %0d command, %0d data, %0d delay (%0d of 500 ms), %0d script ends",
             n_cmd, n_data, n_delay, n_long, n_last);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cli_pkg.sv
rtl/core/cli_in_stage.sv
rtl/core/cli_parser.sv
rtl/core/cli_out_stage.sv
rtl/core/init_command_list_interpreter.sv
bench/tb_top.sv
